@@ rtl/core/qse_pkg.sv @@
// Package for the quicksort engine: sizes, the queue entry type and the
// sequencer state type. No dependencies.
`default_nettype none
package qse_pkg;
    localparam int MAX_ELEMENTS = 32;
    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int DATA_W = 32;
    localparam int CTR_W  = 16;

    // One loaded item as handed from the front to the back
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  idx;    // store slot
        logic              wr;     // store the value (store not full)
        logic              last;   // start the sort
        logic [CNT_W-1:0]  count;  // elements in the set after this item
    } t_qentry;

    typedef enum logic [4:0] {
        S_IDLE, S_POP, S_POP_W, S_PIV, S_LOOP, S_LREQ, S_LCHK, S_RREQ,
        S_RCHK, S_SWAP, S_SWAP2, S_PLACE, S_PLACE2, S_PUSH1, S_PUSH2,
        S_OREQ, S_OLD, S_OWAIT
    } t_state;
endpackage
`default_nettype wire

@@ rtl/core/qse_front.sv @@
// Front of the quicksort engine: accepts items, assigns store slots,
// and queues them for the back. Depends on qse_pkg.
`default_nettype none
module qse_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [qse_pkg::DATA_W-1:0] i_value,
    input  wire logic                      i_last,
    output logic                           o_q_valid,
    output qse_pkg::t_qentry               o_q_entry,
    input  wire logic                      i_q_pop
);
    import qse_pkg::*;

    t_qentry          r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_fill;
    logic [CNT_W-1:0] r_count, n_count;
    t_qentry          w_entry;
    logic             w_acc;

    assign o_stall   = (r_fill == 2'd2);
    assign w_acc     = i_valid && !o_stall;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_entry = r_q[r_rp];

    // classify: slot or drop, count after this item
    always_comb begin
        w_entry.value = i_value;
        w_entry.idx   = r_count[IDX_W-1:0];
        w_entry.last  = i_last;
        if (r_count < CNT_W'(MAX_ELEMENTS)) begin
            w_entry.wr    = 1'b1;
            w_entry.count = r_count + 1'b1;
        end else begin
            w_entry.wr    = 1'b0;
            w_entry.count = r_count;
        end
        n_count = r_count;
        if (w_acc) begin
            n_count = i_last ? '0 : w_entry.count;
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_entry;
        end
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_acc) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_fill <= r_fill + {1'b0, w_acc} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/qse_back.sv @@
// Back of the quicksort engine: element store, range stack, partition
// sequencer and result register. Depends on qse_pkg.
`default_nettype none
module qse_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  wire qse_pkg::t_qentry           i_q_entry,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [qse_pkg::DATA_W-1:0]      o_sorted_value,
    output logic                            o_last_res,
    output logic [qse_pkg::CTR_W-1:0]       o_compare_count,
    output logic [qse_pkg::CTR_W-1:0]       o_move_count
);
    import qse_pkg::*;

    t_state r_state, n_state;

    // store and stack memories
    logic [DATA_W-1:0]  r_mem [MAX_ELEMENTS];
    logic [2*IDX_W-1:0] r_stk [MAX_ELEMENTS];
    logic [DATA_W-1:0]  r_rd;
    logic [2*IDX_W-1:0] r_srd;
    logic               w_we, w_swe;
    logic [IDX_W-1:0]   w_wa, w_ra, w_swa, w_sra;
    logic [DATA_W-1:0]  w_wd;
    logic [2*IDX_W-1:0] w_swd;

    logic [IDX_W-1:0]  r_lo, r_hi, r_j, r_k;
    logic [IDX_W-1:0]  n_lo, n_hi, n_j, n_k;
    logic [CNT_W-1:0]  r_i, n_i, r_n, n_n, r_sp, n_sp;
    logic [DATA_W-1:0] r_pivot, n_pivot, r_vi, n_vi, r_vj, n_vj;
    logic [CTR_W-1:0]  r_cmp, n_cmp, r_mov, n_mov;
    logic              r_oval, n_oval, r_olast, n_olast;
    logic [DATA_W-1:0] r_oval_d, n_oval_d;
    logic              w_le, w_cmp_inc, w_mov_inc;
    logic [CNT_W-1:0]  w_lo6, w_hi6, w_j6;

    assign w_le  = $signed(r_rd) <= $signed(r_pivot);
    assign w_lo6 = {1'b0, r_lo};
    assign w_hi6 = {1'b0, r_hi};
    assign w_j6  = {1'b0, r_j};
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_q_valid && i_q_entry.last)
                          n_state = (i_q_entry.count > CNT_W'(1)) ? S_POP : S_OREQ;
            S_POP:    n_state = (r_sp == '0) ? S_OREQ : S_POP_W;
            S_POP_W:  n_state = S_PIV;
            S_PIV:    n_state = S_LOOP;
            S_LOOP:   n_state = (r_i <= w_j6) ? S_LREQ : S_PLACE;
            S_LREQ:   n_state = (r_i <= w_hi6) ? S_LCHK : S_RREQ;
            S_LCHK:   n_state = w_le ? S_LREQ : S_RREQ;
            S_RREQ:   n_state = S_RCHK;
            S_RCHK:   n_state = !w_le ? S_RREQ : ((r_i < w_j6) ? S_SWAP : S_LOOP);
            S_SWAP:   n_state = S_SWAP2;
            S_SWAP2:  n_state = S_LOOP;
            S_PLACE:  n_state = (r_lo < r_j) ? S_PLACE2 : S_PUSH1;
            S_PLACE2: n_state = S_PUSH1;
            S_PUSH1:  n_state = S_PUSH2;
            S_PUSH2:  n_state = S_POP;
            S_OREQ:   n_state = S_OLD;
            S_OLD:    n_state = S_OWAIT;
            S_OWAIT:  if (!i_stall) n_state = r_olast ? S_IDLE : S_OREQ;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_lo = r_lo;  n_hi = r_hi;  n_i = r_i;  n_j = r_j;  n_k = r_k;
        n_n = r_n;  n_sp = r_sp;  n_pivot = r_pivot;  n_vi = r_vi;  n_vj = r_vj;
        n_cmp = r_cmp;  n_mov = r_mov;
        n_oval = r_oval;  n_olast = r_olast;  n_oval_d = r_oval_d;
        w_we = 1'b0;  w_wa = '0;  w_wd = '0;  w_ra = '0;
        w_swe = 1'b0;  w_swa = r_sp[IDX_W-1:0];  w_swd = '0;
        w_sra = '0;
        w_cmp_inc = 1'b0;  w_mov_inc = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    w_we = i_q_entry.wr;
                    w_wa = i_q_entry.idx;
                    w_wd = i_q_entry.value;
                    if (i_q_entry.last) begin
                        n_n   = i_q_entry.count;
                        n_k   = '0;
                        n_cmp = '0;
                        n_mov = '0;
                        n_sp  = '0;
                        if (i_q_entry.count > CNT_W'(1)) begin
                            w_swe = 1'b1;
                            w_swa = '0;
                            w_swd = {IDX_W'(0), IDX_W'(i_q_entry.count - 1'b1)};
                            n_sp  = CNT_W'(1);
                        end
                    end
                end
            end
            S_POP: begin
                w_sra = IDX_W'(r_sp - 1'b1);
                if (r_sp != '0) n_sp = r_sp - 1'b1;
            end
            S_POP_W: begin
                n_lo = r_srd[2*IDX_W-1:IDX_W];
                n_hi = r_srd[IDX_W-1:0];
                w_ra = r_srd[2*IDX_W-1:IDX_W];
            end
            S_PIV: begin
                n_pivot = r_rd;
                n_i     = w_lo6 + 1'b1;
                n_j     = r_hi;
            end
            S_LREQ: begin
                w_ra = r_i[IDX_W-1:0];
                if (r_i > w_hi6) w_cmp_inc = 1'b1;
            end
            S_LCHK: begin
                w_cmp_inc = 1'b1;
                if (w_le) n_i = r_i + 1'b1;
                else      n_vi = r_rd;
            end
            S_RREQ: w_ra = r_j;
            S_RCHK: begin
                w_cmp_inc = 1'b1;
                if (!w_le) n_j = r_j - 1'b1;
                else       n_vj = r_rd;
            end
            S_SWAP: begin
                w_we = 1'b1;  w_wa = r_i[IDX_W-1:0];  w_wd = r_vj;
                w_mov_inc = 1'b1;
            end
            S_SWAP2: begin
                w_we = 1'b1;  w_wa = r_j;  w_wd = r_vi;
            end
            S_PLACE: begin
                if (r_lo < r_j) begin
                    w_we = 1'b1;  w_wa = r_lo;  w_wd = r_vj;
                    w_mov_inc = 1'b1;
                end
            end
            S_PLACE2: begin
                w_we = 1'b1;  w_wa = r_j;  w_wd = r_pivot;
            end
            S_PUSH1: begin
                // left part holds at least two elements
                if (w_j6 > w_lo6 + 1'b1) begin
                    w_swe = 1'b1;
                    w_swd = {r_lo, r_j - 1'b1};
                    n_sp  = r_sp + 1'b1;
                end
            end
            S_PUSH2: begin
                if (w_hi6 > w_j6 + 1'b1) begin
                    w_swe = 1'b1;
                    w_swd = {r_j + 1'b1, r_hi};
                    n_sp  = r_sp + 1'b1;
                end
            end
            S_OREQ: w_ra = r_k;
            S_OLD: begin
                n_oval   = 1'b1;
                n_oval_d = r_rd;
                n_olast  = ({1'b0, r_k} == r_n - 1'b1);
            end
            S_OWAIT: begin
                if (!i_stall) begin
                    n_oval = 1'b0;
                    n_k    = r_k + 1'b1;
                end
            end
            default: ;
        endcase
        if (w_cmp_inc && r_cmp != '1) n_cmp = r_cmp + 1'b1;
        if (w_mov_inc && r_mov != '1) n_mov = r_mov + 1'b1;
    end

    // memories with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
        if (w_swe) r_stk[w_swa] <= w_swd;
        r_srd <= r_stk[w_sra];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;  r_hi <= n_hi;  r_i <= n_i;  r_j <= n_j;
        r_pivot <= n_pivot;  r_vi <= n_vi;  r_vj <= n_vj;
        r_oval_d <= n_oval_d;  r_olast <= n_olast;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_k     <= '0;
            r_n     <= '0;
            r_cmp   <= '0;
            r_mov   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_k     <= n_k;
            r_n     <= n_n;
            r_cmp   <= n_cmp;
            r_mov   <= n_mov;
            r_oval  <= n_oval;
        end
    end

    assign o_valid         = r_oval;
    assign o_sorted_value  = r_oval_d;
    assign o_last_res      = r_olast;
    assign o_compare_count = r_cmp;
    assign o_move_count    = r_mov;

    // pending ranges are disjoint and hold two or more elements each
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CNT_W'(MAX_ELEMENTS / 2))
        else $error("range stack deeper than possible");

    a_oval_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> (r_state == S_OWAIT))
        else $error("result valid outside output wait");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LCHK) |-> (r_i <= w_hi6))
        else $error("left scan read beyond range end");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !r_oval)
        else $error("queue popped while a result is pending");
endmodule
`default_nettype wire

@@ rtl/core/quicksort_engine_unit.sv @@
// Top level of the quicksort engine: front queue and sort back end.
// Depends on qse_pkg, qse_front and qse_back.
`default_nettype none
// Load a set of signed 32-bit values, one per transaction, with i_last on
// the final one; up to 32 are kept and extra values are dropped. The last
// transaction starts an in-place quicksort (first element as pivot) in a
// store with one read and one write port, then the set comes out ascending,
// one result per stored value, o_last_res on the final one, each carrying
// the saturating compare and swap counts of that sort. Loading runs one
// transaction per cycle into a two-entry queue while it is not full
// (o_stall); the back end takes from the queue only while idle. Every
// comparison, swap, partitioned range and result goes through the one store
// read port and its registered read.
module quicksort_engine_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [qse_pkg::DATA_W-1:0] i_value,
    input  wire logic                       i_last,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [qse_pkg::DATA_W-1:0]      o_sorted_value,
    output logic                            o_last_res,
    output logic [qse_pkg::CTR_W-1:0]       o_compare_count,
    output logic [qse_pkg::CTR_W-1:0]       o_move_count
);
    import qse_pkg::*;

    logic    w_q_valid, w_q_pop;
    t_qentry w_q_entry;

    qse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_value   (i_value),
        .i_last    (i_last),
        .o_q_valid (w_q_valid),
        .o_q_entry (w_q_entry),
        .i_q_pop   (w_q_pop)
    );

    qse_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_entry       (w_q_entry),
        .o_q_pop         (w_q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sorted_value  (o_sorted_value),
        .o_last_res      (o_last_res),
        .o_compare_count (o_compare_count),
        .o_move_count    (o_move_count)
    );
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for quicksort_engine_unit: loads signed value sets, predicts the
// sorted output and the compare/swap counts, and checks every result.
// Depends on qse_pkg and the RTL of quicksort_engine_unit.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qse_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
    } t_load;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        logic [CTR_W-1:0]  cmp;
        logic [CTR_W-1:0]  mov;
    } t_sorted;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [DATA_W-1:0]    i_value = '0;
    logic                 i_last = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [DATA_W-1:0]    o_sorted_value;
    logic                 o_last_res;
    logic [CTR_W-1:0]     o_compare_count;
    logic [CTR_W-1:0]     o_move_count;

    quicksort_engine_unit u_top (.*);

    always #1 i_clk = ~i_clk;

    t_load   load_queue[$];
    t_sorted sorted_expect[$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    bit      hold_send = 1'b0;
    bit      stim_done = 1'b0;
    bit      in_acc = 1'b0;     // input transaction taken at the last rising edge

    // predictor state: keys with sign bit flipped so unsigned order == signed
    logic [31:0] set_keys[MAX_ELEMENTS];
    int          set_size = 0;
    logic [31:0] cmp_ctr, mov_ctr;

    function automatic logic [31:0] sat_inc(logic [31:0] c);
        return (c < 32'hFFFF) ? c + 1 : c;
    endfunction

    task automatic key_swap(int a, int b);
        logic [31:0] t;
        t = set_keys[a];
        set_keys[a] = set_keys[b];
        set_keys[b] = t;
    endtask

    // first-element-pivot quicksort with explicit range stack
    task automatic sort_set();
        int lo_stk[$], hi_stk[$];
        int lo, hi, i, j;
        logic [31:0] pivot;
        cmp_ctr = 0;
        mov_ctr = 0;
        if (set_size > 1) begin
            lo_stk.push_back(0);
            hi_stk.push_back(set_size - 1);
        end
        while (lo_stk.size() > 0) begin
            lo = lo_stk.pop_back();
            hi = hi_stk.pop_back();
            pivot = set_keys[lo];
            i = lo + 1;
            j = hi;
            while (i <= j) begin
                while (i <= hi && set_keys[i] <= pivot) begin
                    i++;
                    cmp_ctr = sat_inc(cmp_ctr);
                end
                cmp_ctr = sat_inc(cmp_ctr);
                while (j >= lo && set_keys[j] > pivot) begin
                    j--;
                    cmp_ctr = sat_inc(cmp_ctr);
                end
                cmp_ctr = sat_inc(cmp_ctr);
                if (i < j) begin
                    key_swap(i, j);
                    mov_ctr = sat_inc(mov_ctr);
                end
            end
            if (lo < j) begin
                key_swap(lo, j);
                mov_ctr = sat_inc(mov_ctr);
            end
            if (j > lo && j - 1 > lo) begin
                lo_stk.push_back(lo);
                hi_stk.push_back(j - 1);
            end
            if (hi > j + 1) begin
                lo_stk.push_back(j + 1);
                hi_stk.push_back(hi);
            end
        end
    endtask

    task automatic predict_load(t_load it);
        t_sorted r;
        if (set_size < MAX_ELEMENTS) begin
            set_keys[set_size] = it.value ^ 32'h8000_0000;
            set_size++;
        end
        if (it.last) begin
            sort_set();
            for (int k = 0; k < set_size; k++) begin
                r.value = set_keys[k] ^ 32'h8000_0000;
                r.last  = (k + 1 == set_size);
                r.cmp   = cmp_ctr[CTR_W-1:0];
                r.mov   = mov_ctr[CTR_W-1:0];
                sorted_expect.push_back(r);
            end
            set_size = 0;
        end
    endtask

    function automatic logic [31:0] rand_value(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 7) - 4;
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7FFF_FFF0}
                      + $urandom_range(0, 31);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic add_set(int n, int mode);
        t_load it;
        for (int k = 0; k < n; k++) begin
            it.value = rand_value(mode);
            it.last  = (k == n - 1);
            load_queue.push_back(it);
        end
    endtask

    task automatic add_fixed(logic [31:0] v, logic l);
        t_load it;
        it.value = v;
        it.last  = l;
        load_queue.push_back(it);
    endtask

    // driver: next transaction presented at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_acc) begin
                predict_load(t_load'{value: i_value, last: i_last});
                void'(load_queue.pop_front());
            end
            if (!i_valid || in_acc) begin
                if (load_queue.size() > 0 && !hold_send
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_value <= load_queue[0].value;
                    i_last  <= load_queue[0].last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor: compare accepted results against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_acc = i_valid && !o_stall;
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall) begin
                if (sorted_expect.size() == 0) begin
                    $display("%0t unexpected result value=%0d", $realtime,
                             $signed(o_sorted_value));
                    fail_count++;
                end else begin
                    if (o_sorted_value !== sorted_expect[0].value
                            || o_last_res !== sorted_expect[0].last
                            || o_compare_count !== sorted_expect[0].cmp
                            || o_move_count !== sorted_expect[0].mov) begin
                        $display("%0t mismatch exp v=%0d l=%0b c=%0d m=%0d got v=%0d l=%0b c=%0d m=%0d",
                                 $realtime, $signed(sorted_expect[0].value),
                                 sorted_expect[0].last, sorted_expect[0].cmp,
                                 sorted_expect[0].mov, $signed(o_sorted_value),
                                 o_last_res, o_compare_count, o_move_count);
                        fail_count++;
                    end
                    void'(sorted_expect.pop_front());
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[quicksort_engine_unit] ERROR");
                $finish;
            end
        end
    end

    task automatic drain();
        while (load_queue.size() > 0 || i_valid) @(posedge i_clk);
        while (sorted_expect.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        // directed sets: extremes, single element, duplicates, sorted and reverse-sorted input
        add_fixed(32'h8000_0000, 1'b1);
        add_fixed(32'h7FFF_FFFF, 1'b0);
        add_fixed(32'h8000_0000, 1'b0);
        add_fixed(32'h0000_0000, 1'b0);
        add_fixed(32'hFFFF_FFFF, 1'b1);
        add_fixed(32'h5, 1'b0);
        add_fixed(32'h5, 1'b0);
        add_fixed(32'h5, 1'b1);
        for (int k = 0; k < 6; k++) add_fixed(k, k == 5);
        for (int k = 0; k < 6; k++) add_fixed(-k, k == 5);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 11;
        stall_pct = 73;
        drain();
        // store overflow: 36 items, last four dropped
        add_set(36, 0);
        drain();
        // hold the next set back in the load queue, then resume
        hold_send = 1'b1;
        add_set(8, 1);
        repeat (20) @(posedge i_clk);
        hold_send = 1'b0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 73 : 0;
            stall_pct     = (ph == 0) ? 73 : (ph == 1) ? 11 : 0;
            n = 0;
            while (n < 80) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_set(32, $urandom_range(0, 3));
                    n += 32;
                end else begin
                    add_set($urandom_range(1, 10), $urandom_range(0, 3));
                    n += 6;
                end
            end
            drain();
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && sorted_expect.size() == 0)
            $display("[quicksort_engine_unit] OK");
        else
            $display("[quicksort_engine_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
